>>> sv/mfd_pkg.sv
// Package for the mesh frame deframer: phase codes, frame constants and the
// structs passed between the phase machine, output register and top level.
// No dependencies.
`timescale 1ns / 1ps

package mfd_pkg;

	// Frame delimiters
	localparam logic [7:0]  SYNC_FIRST  = 8'hF1;
	localparam logic [7:0]  SYNC_SECOND = 8'hDD;
	localparam logic [15:0] TERMINATOR  = 16'h0D0A;

	// Position within the frame, one-hot
	typedef enum logic [11:0] {
		PH_HUNT    = 12'b0000_0000_0001,
		PH_SYNC2   = 12'b0000_0000_0010,
		PH_NET_ID  = 12'b0000_0000_0100,
		PH_SRC_HI  = 12'b0000_0000_1000,
		PH_SRC_LO  = 12'b0000_0001_0000,
		PH_DST_HI  = 12'b0000_0010_0000,
		PH_DST_LO  = 12'b0000_0100_0000,
		PH_KEY     = 12'b0000_1000_0000,
		PH_LEFT    = 12'b0001_0000_0000,
		PH_RIGHT   = 12'b0010_0000_0000,
		PH_TERM_HI = 12'b0100_0000_0000,
		PH_TERM_LO = 12'b1000_0000_0000
	} mfd_phase_t;

	// One decoded frame
	typedef struct packed {
		logic [7:0]  net_id;
		logic [15:0] src_addr;
		logic [15:0] dst_addr;
		logic [7:0]  key_byte;
		logic [7:0]  left_value;
		logic [7:0]  right_value;
		logic        frame_status;
	} mfd_frame_t;

	// Phase machine status towards the top level
	typedef struct packed {
		mfd_phase_t phase;
		logic       frame_end;
	} mfd_fsm_stat_t;

	// Frame hand-over from phase machine to output register
	typedef struct packed {
		logic       load;
		mfd_frame_t frame;
	} mfd_emit_t;

endpackage

>>> sv/mfd_if.sv
// Handshake channels of the mesh frame deframer: received byte stream and
// decoded frame stream. No dependencies.
`timescale 1ns / 1ps

interface mfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfd_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  net_id;
	logic [15:0] src_addr;
	logic [15:0] dst_addr;
	logic [7:0]  key_byte;
	logic [7:0]  left_value;
	logic [7:0]  right_value;
	logic        frame_status;

	modport source (output valid, output net_id, output src_addr, output dst_addr,
		output key_byte, output left_value, output right_value,
		output frame_status, input ready);
	modport sink (input valid, input net_id, input src_addr, input dst_addr,
		input key_byte, input left_value, input right_value,
		input frame_status, output ready);
endinterface

>>> sv/mfd_phase_fsm.sv
// Phase machine of the mesh frame deframer: hunts for sync, captures the
// header and value bytes and checks the terminator. Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_phase_fsm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	output mfd_pkg::mfd_fsm_stat_t stat,
	output mfd_pkg::mfd_emit_t     emit
);
	import mfd_pkg::*;

	mfd_phase_t  phase_q;
	mfd_phase_t  phase_nxt;
	logic [7:0]  net_id_q;
	logic [15:0] src_q;
	logic [15:0] dst_q;
	logic [7:0]  key_q;
	logic [7:0]  left_q;
	logic [7:0]  right_q;
	logic [7:0]  term_hi_q;
	mfd_phase_t  hunt_nxt;

	// A byte that fails the sync is checked again as a first sync byte
	assign hunt_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;

	// Next phase
	always_comb begin
		case (phase_q)
			PH_SYNC2:   phase_nxt = (rx_byte == SYNC_SECOND) ? PH_NET_ID : hunt_nxt;
			PH_NET_ID:  phase_nxt = PH_SRC_HI;
			PH_SRC_HI:  phase_nxt = PH_SRC_LO;
			PH_SRC_LO:  phase_nxt = PH_DST_HI;
			PH_DST_HI:  phase_nxt = PH_DST_LO;
			PH_DST_LO:  phase_nxt = PH_KEY;
			PH_KEY:     phase_nxt = PH_LEFT;
			PH_LEFT:    phase_nxt = PH_RIGHT;
			PH_RIGHT:   phase_nxt = PH_TERM_HI;
			PH_TERM_HI: phase_nxt = PH_TERM_LO;
			PH_TERM_LO: phase_nxt = PH_HUNT;
			default:    phase_nxt = hunt_nxt;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (accept) begin
			phase_q <= phase_nxt;
		end
	end

	// Field capture; every field is written before a frame can complete
	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_NET_ID:  net_id_q        <= rx_byte;
				PH_SRC_HI:  src_q[15:8]     <= rx_byte;
				PH_SRC_LO:  src_q[7:0]      <= rx_byte;
				PH_DST_HI:  dst_q[15:8]     <= rx_byte;
				PH_DST_LO:  dst_q[7:0]      <= rx_byte;
				PH_KEY:     key_q           <= rx_byte;
				PH_LEFT:    left_q          <= rx_byte;
				PH_RIGHT:   right_q         <= rx_byte;
				PH_TERM_HI: term_hi_q       <= rx_byte;
				default:    ;
			endcase
		end
	end

	// Frame hand-over on the last terminator beat
	assign emit.load               = accept && (phase_q == PH_TERM_LO);
	assign emit.frame.net_id       = net_id_q;
	assign emit.frame.src_addr     = src_q;
	assign emit.frame.dst_addr     = dst_q;
	assign emit.frame.key_byte     = key_q;
	assign emit.frame.left_value   = left_q;
	assign emit.frame.right_value  = right_q;
	assign emit.frame.frame_status = ({term_hi_q, rx_byte} != TERMINATOR);

	assign stat.phase     = phase_q;
	assign stat.frame_end = (phase_q == PH_TERM_LO);

endmodule

>>> sv/mfd_out_reg.sv
// Output register of the mesh frame deframer: holds one decoded frame until
// the sink takes it. Depends on mfd_pkg and mfd_frame_if.
`timescale 1ns / 1ps

module mfd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  mfd_pkg::mfd_emit_t emit,
	mfd_frame_if.source        frm
);
	import mfd_pkg::*;

	logic       valid_q;
	mfd_frame_t frame_q;

	// Valid flag: set on load, cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.load) begin
			valid_q <= 1'b1;
		end else if (frm.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			frame_q <= emit.frame;
		end
	end

	assign frm.valid        = valid_q;
	assign frm.net_id       = frame_q.net_id;
	assign frm.src_addr     = frame_q.src_addr;
	assign frm.dst_addr     = frame_q.dst_addr;
	assign frm.key_byte     = frame_q.key_byte;
	assign frm.left_value   = frame_q.left_value;
	assign frm.right_value  = frame_q.right_value;
	assign frm.frame_status = frame_q.frame_status;

endmodule

>>> sv/mesh_frame_deframer.sv
// Top level of the mesh frame deframer: phase machine plus output register.
// Depends on mfd_pkg, mfd_if, mfd_phase_fsm and mfd_out_reg.
//
//   channel | dir | beat content
//   --------+-----+-------------------------------------------------------
//   rx      | in  | rx_byte: one received byte
//   frm     | out | net_id, src_addr, dst_addr, key_byte, left_value,
//           |     | right_value, frame_status: one decoded frame
//
// One byte is taken per cycle; a frame appears on frm the cycle after its
// last terminator byte is taken. rx.ready drops only while the final
// terminator byte is due and the output register still holds an untaken
// frame. Reset returns the phase machine to hunting and empties the output.
`timescale 1ns / 1ps

module mesh_frame_deframer (
	input  logic         clk,
	input  logic         arst_n,
	mfd_byte_if.sink     rx,
	mfd_frame_if.source  frm
);
	import mfd_pkg::*;

	mfd_fsm_stat_t stat;
	mfd_emit_t     emit;
	logic          accept;

	// Only the frame-completing beat needs room in the output register
	assign rx.ready = !(stat.frame_end && frm.valid && !frm.ready);
	assign accept   = rx.valid && rx.ready;

	mfd_phase_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.stat    (stat),
		.emit    (emit)
	);

	mfd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.emit   (emit),
		.frm    (frm)
	);

	// Phase register stays one-hot
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(stat.phase))
		else $error("phase register not one-hot");

	// Back-pressure only on the last terminator byte with a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (stat.phase == PH_TERM_LO) && frm.valid)
		else $error("input stalled without cause");

	// A completed frame is presented in the next cycle
	a_frame_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stat.frame_end |=> frm.valid && (stat.phase == PH_HUNT))
		else $error("completed frame not presented");

endmodule
